/* hw/rtl/ialu_pkg.sv */
// ----------------------------------------------------------------------------
// ialu_pkg
// shared types and codes for the integer alu with gcd and lcm
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int OperandWidth = 32;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_GCD = 3'd4,
        MODE_LCM = 3'd5,
        MODE_RSV6 = 3'd6,
        MODE_RSV7 = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_NEGOP    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [OperandWidth-1:0] operand_a;
        logic signed [OperandWidth-1:0] operand_b;
    } in_beat_t;

    typedef struct packed {
        logic signed [OperandWidth-1:0] result;
        logic [1:0]               status;
    } out_beat_t;

    // datapath commands
    typedef struct packed {
        logic load;      // capture operands and classify
        logic div_start; // start a divide of x by y
        logic div_step;  // one restoring step
        logic gcd_next;  // x <= y, y <= remainder, rearm the divider
        logic lcm_quot;  // start a / g
        logic mul_start; // start product
        logic mul_step;
        logic finish;    // form result
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic y_zero;
        logic direct;    // add, sub, trivial cases: finish now
        logic is_div;
        logic is_lcm;
        logic is_mul;
    } dp_stat_t;

endpackage

/* hw/rtl/ialu_datapath.sv */
// ----------------------------------------------------------------------------
// ialu_datapath
// operand registers, shared restoring divider and shift-add multiplier
// ----------------------------------------------------------------------------
module ialu_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ialu_pkg::in_beat_t   in_beat,
    input  ialu_pkg::dp_cmd_t    cmd,
    output ialu_pkg::dp_stat_t   stat,
    output ialu_pkg::out_beat_t  out_beat
);
    localparam int W  = ialu_pkg::OperandWidth;
    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};

    logic [2:0]   mode_reg;
    logic [W-1:0] a_reg, b_reg, ma_reg, mb_reg;
    logic         neg_reg;
    logic [W-1:0] x_reg, y_reg;         // divider dividend/divisor, gcd pair
    logic [W-1:0] rem_reg;
    logic [2*W-1:0] acc_reg, mcand_reg;
    logic [W-1:0] mplier_reg;
    logic [CW-1:0] cnt_reg;
    logic         busy_div_reg, busy_mul_reg;
    ialu_pkg::out_beat_t out_reg;

    logic [W-1:0] a_in, b_in;
    logic [W:0]   trial;
    logic [W:0]   rem_sh;

    // result forming
    logic [W-1:0] sum, dif, prod_lo, quot;
    logic         mul_ovf, mag_ovf;
    ialu_pkg::out_beat_t out_next;
    logic [W-1:0] r_w;
    ialu_pkg::status_t st;
    logic         neg_op;

    assign a_in = W'(in_beat.operand_a);
    assign b_in = W'(in_beat.operand_b);

    assign rem_sh = {rem_reg, x_reg[W-1]};
    assign trial  = rem_sh - {1'b0, y_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_div_reg <= 1'b0;
            busy_mul_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cmd.div_start || cmd.lcm_quot || cmd.gcd_next)
            begin
                busy_div_reg <= 1'b1;
                cnt_reg      <= CW'(W);
            end
            else if (cmd.mul_start)
            begin
                busy_mul_reg <= 1'b1;
                cnt_reg      <= CW'(W);
            end
            else if (cmd.div_step && busy_div_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    busy_div_reg <= 1'b0;
            end
            else if (cmd.mul_step && busy_mul_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    busy_mul_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_beat.mode;
            a_reg    <= a_in;
            b_reg    <= b_in;
            ma_reg   <= a_in[W-1] ? (W'(0) - a_in) : a_in;
            mb_reg   <= b_in[W-1] ? (W'(0) - b_in) : b_in;
            neg_reg  <= a_in[W-1] ^ b_in[W-1];
        end
        if (cmd.div_start)
        begin
            // divide: magnitudes; gcd: raw positives
            if (mode_reg == ialu_pkg::MODE_DIV)
            begin
                x_reg <= ma_reg;
                y_reg <= mb_reg;
            end
            else
            begin
                x_reg <= a_reg;
                y_reg <= b_reg;
            end
            rem_reg <= '0;
        end
        else if (cmd.lcm_quot)
        begin
            x_reg   <= a_reg;
            y_reg   <= x_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step && busy_div_reg)
        begin
            x_reg <= {x_reg[W-2:0], ~trial[W]};
            rem_reg <= trial[W] ? rem_sh[W-1:0] : trial[W-1:0];
        end
        else if (cmd.gcd_next)
        begin
            // x holds the quotient bits now; keep the divisor and remainder
            x_reg <= y_reg;
            y_reg <= rem_reg;
            rem_reg <= '0;
        end
        if (cmd.mul_start)
        begin
            acc_reg <= '0;
            if (mode_reg == ialu_pkg::MODE_LCM)
            begin
                mcand_reg  <= {{W{1'b0}}, x_reg};  // a / gcd
                mplier_reg <= b_reg;
            end
            else
            begin
                mcand_reg  <= {{W{1'b0}}, ma_reg};
                mplier_reg <= mb_reg;
            end
        end
        else if (cmd.mul_step && busy_mul_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[2*W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[W-1:1]};
        end
        if (cmd.finish)
            out_reg <= out_next;
    end

    assign sum = a_reg + b_reg;
    assign dif = a_reg - b_reg;
    assign mag_ovf = neg_reg ? (acc_reg > {{W{1'b0}}, MinNeg})
                             : (acc_reg > {{W{1'b0}}, MaxPos});
    assign prod_lo = neg_reg ? (W'(0) - acc_reg[W-1:0]) : acc_reg[W-1:0];
    assign mul_ovf = (acc_reg > {{W{1'b0}}, MaxPos});
    assign quot = neg_reg ? (W'(0) - x_reg) : x_reg;

    always_comb
    begin
        r_w = '0;
        st  = ialu_pkg::ST_OK;
        unique case (ialu_pkg::mode_t'(mode_reg))
            ialu_pkg::MODE_ADD:
            begin
                r_w = sum;
                if (a_reg[W-1] == b_reg[W-1] && sum[W-1] != a_reg[W-1])
                    st = ialu_pkg::ST_OVERFLOW;
            end
            ialu_pkg::MODE_SUB:
            begin
                r_w = dif;
                if (a_reg[W-1] != b_reg[W-1] && dif[W-1] != a_reg[W-1])
                    st = ialu_pkg::ST_OVERFLOW;
            end
            ialu_pkg::MODE_MUL:
            begin
                r_w = prod_lo;
                if (mag_ovf)
                    st = ialu_pkg::ST_OVERFLOW;
            end
            ialu_pkg::MODE_DIV:
            begin
                if (b_reg == '0)
                    st = ialu_pkg::ST_DIVZERO;
                else
                begin
                    r_w = quot;
                    if (!neg_reg && x_reg[W-1])
                        st = ialu_pkg::ST_OVERFLOW;
                end
            end
            ialu_pkg::MODE_GCD:
            begin
                if (a_reg[W-1] || b_reg[W-1])
                    st = ialu_pkg::ST_NEGOP;
                else
                    r_w = x_reg;
            end
            ialu_pkg::MODE_LCM:
            begin
                if (a_reg[W-1] || b_reg[W-1])
                    st = ialu_pkg::ST_NEGOP;
                else if (a_reg != '0 && b_reg != '0)
                begin
                    r_w = acc_reg[W-1:0];
                    if (mul_ovf)
                        st = ialu_pkg::ST_OVERFLOW;
                end
            end
            default: ;
        endcase
        out_next.result = r_w;
        out_next.status = st;
    end

    assign neg_op = a_reg[W-1] || b_reg[W-1];

    assign stat.div_done = !busy_div_reg;
    assign stat.mul_done = !busy_mul_reg;
    assign stat.y_zero   = (y_reg == '0);
    assign stat.is_div   = (mode_reg == ialu_pkg::MODE_DIV);
    assign stat.is_lcm   = (mode_reg == ialu_pkg::MODE_LCM);
    assign stat.is_mul   = (mode_reg == ialu_pkg::MODE_MUL);
    assign stat.direct   = (mode_reg == ialu_pkg::MODE_ADD)
                        || (mode_reg == ialu_pkg::MODE_SUB)
                        || (mode_reg == ialu_pkg::MODE_RSV6)
                        || (mode_reg == ialu_pkg::MODE_RSV7)
                        || ((mode_reg == ialu_pkg::MODE_DIV) && b_reg == '0)
                        || ((mode_reg == ialu_pkg::MODE_GCD
                             || mode_reg == ialu_pkg::MODE_LCM) && neg_op)
                        || ((mode_reg == ialu_pkg::MODE_LCM)
                            && (a_reg == '0 || b_reg == '0));

    assign out_beat = out_reg;
endmodule

/* hw/rtl/ialu_ctrl.sv */
// ----------------------------------------------------------------------------
// ialu_ctrl
// sequencer for the alu: load, divide loops, multiply, result hand-off
// ----------------------------------------------------------------------------
module ialu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  ialu_pkg::dp_stat_t stat,
    output ialu_pkg::dp_cmd_t  cmd
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_GCDCHK = 8'b0000_1000,
        S_QUOT   = 8'b0001_0000,
        S_MUL    = 8'b0010_0000,
        S_FIN    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   lcm_phase_reg, lcm_phase_next;  // quotient a / g under way

    // accept while idle even if a result still waits
    logic can_take;
    assign can_take = (state_reg == S_IDLE);
    assign in_stall = !can_take;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            lcm_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            lcm_phase_reg <= lcm_phase_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        lcm_phase_next = lcm_phase_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    lcm_phase_next = 1'b0;
                    state_next     = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.direct)
                    state_next = S_FIN;
                else if (stat.is_mul)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    // gcd starts with the zero check on y
                    state_next    = stat.is_div ? S_DIV : S_GCDCHK;
                end
            end
            S_GCDCHK:
            begin
                if (stat.y_zero)
                begin
                    if (stat.is_lcm)
                    begin
                        cmd.lcm_quot   = 1'b1;
                        lcm_phase_next = 1'b1;
                        state_next     = S_DIV;
                    end
                    else
                        state_next = S_FIN;
                end
                else
                    state_next = S_DIV;  // divider already armed by the start
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    cmd.div_step = 1'b0;
                    if (stat.is_div)
                        state_next = S_FIN;
                    else if (lcm_phase_reg)
                    begin
                        cmd.mul_start = 1'b1;
                        state_next    = S_MUL;
                    end
                    else
                    begin
                        cmd.gcd_next = 1'b1;
                        state_next   = S_QUOT;
                    end
                end
            end
            S_QUOT:
            begin
                // new pair in place and divider rearmed: test y, else divide again
                if (stat.y_zero)
                begin
                    if (stat.is_lcm)
                    begin
                        cmd.lcm_quot   = 1'b1;
                        lcm_phase_next = 1'b1;
                        state_next     = S_DIV;
                    end
                    else
                        state_next = S_FIN;
                end
                else
                    state_next = S_DIV;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_done)
                begin
                    cmd.mul_step = 1'b0;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule

/* hw/rtl/integer_alu_with_gcd_lcm_unit.sv */
// ----------------------------------------------------------------------------
// integer_alu_with_gcd_lcm_unit
// add, subtract, multiply, divide, gcd and lcm on signed operands, one beat
// ----------------------------------------------------------------------------
// latency from accept to result valid runs through decode, then add/sub/flagged
// cases go straight to finish, multiply and divide run their shift loop, gcd
// a zero check and a divide per euclid step, lcm the gcd, a / g and a multiply
// throughput: one beat at a time, the next taken the cycle after the result
// is formed; a waiting result only holds back forming the next one
// reset: asynchronous active low, controller idle and output empty
module integer_alu_with_gcd_lcm_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ialu_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ialu_pkg::out_beat_t out_data
);
    // command and status between sequencer and datapath
    ialu_pkg::dp_cmd_t  cmd;
    ialu_pkg::dp_stat_t stat;

    ialu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: the divider doubles as the euclid remainder engine
    ialu_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_beat (out_data)
    );
endmodule

/* dv/ialu_checker.sv */
// ----------------------------------------------------------------------------
// ialu_checker
// watches both channels, predicts each result and compares field by field
// ----------------------------------------------------------------------------
module ialu_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  ialu_pkg::in_beat_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  ialu_pkg::out_beat_t out_data,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    ialu_pkg::out_beat_t expected_results[$];

    function automatic logic [31:0] euclid_gcd(logic [31:0] x, logic [31:0] y);
        logic [31:0] r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic ialu_pkg::out_beat_t alu_predict(ialu_pkg::in_beat_t b);
        ialu_pkg::out_beat_t o;
        logic [31:0] a;
        logic [31:0] d;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] g;
        logic [63:0] p;
        logic        neg;
        a = b.operand_a;
        d = b.operand_b;
        ma = a[31] ? -a : a;
        mb = d[31] ? -d : d;
        neg = a[31] != d[31];
        o.result = '0;
        o.status = ialu_pkg::ST_OK;
        case (ialu_pkg::mode_t'(b.mode))
            ialu_pkg::MODE_ADD:
            begin
                o.result = a + d;
                if (a[31] == d[31] && o.result[31] != a[31])
                    o.status = ialu_pkg::ST_OVERFLOW;
            end
            ialu_pkg::MODE_SUB:
            begin
                o.result = a - d;
                if (a[31] != d[31] && o.result[31] != a[31])
                    o.status = ialu_pkg::ST_OVERFLOW;
            end
            ialu_pkg::MODE_MUL:
            begin
                o.result = a * d;
                p = {32'd0, ma} * {32'd0, mb};
                if (p > (neg ? 64'h8000_0000 : 64'h7fff_ffff))
                    o.status = ialu_pkg::ST_OVERFLOW;
            end
            ialu_pkg::MODE_DIV:
            begin
                if (d == 0)
                    o.status = ialu_pkg::ST_DIVZERO;
                else
                begin
                    q = ma / mb;
                    o.result = neg ? -q : q;
                    if (!neg && q > 32'h7fff_ffff)
                        o.status = ialu_pkg::ST_OVERFLOW;
                end
            end
            ialu_pkg::MODE_GCD:
            begin
                if (a[31] || d[31])
                    o.status = ialu_pkg::ST_NEGOP;
                else
                    o.result = euclid_gcd(a, d);
            end
            ialu_pkg::MODE_LCM:
            begin
                if (a[31] || d[31])
                    o.status = ialu_pkg::ST_NEGOP;
                else if (a != 0 && d != 0)
                begin
                    g = euclid_gcd(a, d);
                    p = {32'd0, a / g} * {32'd0, d};
                    o.result = p[31:0];
                    if (p > 64'h7fff_ffff)
                        o.status = ialu_pkg::ST_OVERFLOW;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ialu_pkg::out_beat_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(alu_predict(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result beat %h", out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.result !== out_data.result
                        || want.status !== out_data.status)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected result %h status %0d, got %h %0d",
                                     want.result, want.status, out_data.result,
                                     out_data.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_results.size();
        end
    end
endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// directed and random beats through the alu, checked by ialu_checker
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    ialu_pkg::in_beat_t  in_data;
    logic                out_valid;
    logic                out_stall;
    ialu_pkg::out_beat_t out_data;
    int                  fail_count;
    int                  pending;
    int                  cycle_count;
    int                  stall_left;

    integer_alu_with_gcd_lcm_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    ialu_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // operand picked from edge values, small values and full random words
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 3) - 1;
            3: return $urandom_range(0, 100000);
            4: return -$urandom_range(0, 100000);
            5: return $urandom_range(0, 65535) * $urandom_range(1, 2000);
            default: return $urandom();
        endcase
    endfunction

    // send one beat; valid held until accepted, then dropped or kept
    task automatic send_beat(logic [2:0] m, logic [31:0] a, logic [31:0] b);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_data <= '{mode: m, operand_a: a, operand_b: b};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver stall in stretches of random length, mostly short
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            out_stall  <= 1'b1;
            stall_left <= gap_len();
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 5000000)
        begin
            $display("[integer_alu_with_gcd_lcm_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        logic [2:0]  m;
        int          k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every mode, each special case
        send_beat(ialu_pkg::MODE_ADD, 32'h7fff_ffff, 32'd1);
        send_beat(ialu_pkg::MODE_ADD, 32'h8000_0000, 32'hffff_ffff);
        send_beat(ialu_pkg::MODE_SUB, 32'h8000_0000, 32'd1);
        send_beat(ialu_pkg::MODE_SUB, 32'h7fff_ffff, 32'hffff_ffff);
        send_beat(ialu_pkg::MODE_MUL, 32'h8000_0000, 32'hffff_ffff);
        send_beat(ialu_pkg::MODE_MUL, 32'h0001_0000, 32'hffff_8000);
        send_beat(ialu_pkg::MODE_MUL, 32'h0001_0000, 32'h0000_8000);
        send_beat(ialu_pkg::MODE_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_beat(ialu_pkg::MODE_DIV, 32'd12345, 32'd0);
        send_beat(ialu_pkg::MODE_DIV, -32'sd7, 32'd2);
        send_beat(ialu_pkg::MODE_GCD, 32'd0, 32'd0);
        send_beat(ialu_pkg::MODE_GCD, 32'd0, 32'd18);
        send_beat(ialu_pkg::MODE_GCD, 32'd1836311903, 32'd1134903170);
        send_beat(ialu_pkg::MODE_GCD, 32'hffff_fffc, 32'd6);
        send_beat(ialu_pkg::MODE_LCM, 32'd4, 32'h8000_0000);
        send_beat(ialu_pkg::MODE_LCM, 32'd0, 32'd77);
        send_beat(ialu_pkg::MODE_LCM, 32'd12, 32'd18);
        send_beat(ialu_pkg::MODE_LCM, 32'h7fff_ffff, 32'h7fff_fffe);
        send_beat(ialu_pkg::MODE_RSV6, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(ialu_pkg::MODE_RSV7, 32'h1234_5678, 32'h8765_4321);
        send_beat(ialu_pkg::MODE_GCD, 32'h7fff_ffff, 32'h7fff_ffff);

        for (k = 0; k < 350; k++)
        begin
            m = 3'($urandom_range(0, 7));
            a = pick_operand();
            b = pick_operand();
            // gcd/lcm mostly with non-negative operands to reach euclid
            if ((m == ialu_pkg::MODE_GCD || m == ialu_pkg::MODE_LCM)
                && $urandom_range(0, 9) < 8)
            begin
                a[31] = 1'b0;
                b[31] = 1'b0;
            end
            send_beat(m, a, b);
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("[integer_alu_with_gcd_lcm_unit] OK");
        else
            $display("[integer_alu_with_gcd_lcm_unit] ERROR");
        $finish;
    end
endmodule
